FILE: rtl/core/jte_pkg.sv
// Shared constants for the job table engine: default sizes, operation codes
// and run state codes. No dependencies.
`timescale 1ns / 1ps

package jte_pkg;

  localparam int NUM_ENTRIES_DEF = 16;
  localparam int PID_BITS_DEF    = 22;

  localparam int FUNC_W = 3;
  localparam int ST_W   = 2;

  localparam logic [FUNC_W-1:0] FN_ADD      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FIND_PID = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FIND_JID = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FIRST_FG = 3'd4;
  localparam logic [FUNC_W-1:0] FN_FIRST_ST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd6;

  localparam logic [ST_W-1:0] ST_FG   = 2'd1;
  localparam logic [ST_W-1:0] ST_STOP = 2'd3;

endpackage

FILE: rtl/core/job_table_engine.sv
// Job table engine top level: entry memory, valid bits and the scan sequencer.
// Depends on jte_pkg.
`timescale 1ns / 1ps

// Holds NUM_ENTRIES job entries (pid, job id, run state) in a small memory
// with one read and one write port; a flop valid bit per entry marks used
// slots, so reset and clear all empty the table at once. Each word is handled
// by one compare unit that walks the memory one entry per cycle. Clear all, unused
// codes and rejected zero pid or job id go straight to the result word. Add and
// every lookup scan until the first hit or the last entry. A delete that hits
// rescans all entries for the largest job id. The input side stalls until the
// result word has been taken and accepts the next word in the cycle after.
module job_table_engine
  import jte_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int PID_BITS    = PID_BITS_DEF,
  localparam int JID_W      = $clog2(NUM_ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [PID_BITS-1:0] in_pid,
  input  logic [JID_W-1:0]    in_job_id,
  input  logic [ST_W-1:0]     in_run_state,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_ok,
  output logic [PID_BITS-1:0] out_found_pid,
  output logic [JID_W-1:0]    out_found_job_id,
  output logic [ST_W-1:0]     out_found_state
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MAX  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_ENTRIES);
  localparam logic [JID_W:0]   JID_END  = (JID_W + 1)'(NUM_ENTRIES);

  logic [PID_BITS-1:0] mem_pid [NUM_ENTRIES];
  logic [JID_W-1:0]    mem_jid [NUM_ENTRIES];
  logic [ST_W-1:0]     mem_st  [NUM_ENTRIES];

  logic [1:0]             state_r, state_nxt;
  logic [NUM_ENTRIES-1:0] valid_r, valid_nxt;
  logic [JID_W-1:0]       next_jid_r, next_jid_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic [JID_W-1:0]       max_r, max_nxt;

  logic [FUNC_W-1:0]   op_r, op_nxt;
  logic [PID_BITS-1:0] pid_r, pid_nxt;
  logic [JID_W-1:0]    jid_r, jid_nxt;
  logic [ST_W-1:0]     st_r, st_nxt;

  logic                res_ok_r, res_ok_nxt;
  logic [PID_BITS-1:0] res_pid_r, res_pid_nxt;
  logic [JID_W-1:0]    res_jid_r, res_jid_nxt;
  logic [ST_W-1:0]     res_st_r, res_st_nxt;

  logic                q_v_r;
  logic [PID_BITS-1:0] q_pid_r;
  logic [JID_W-1:0]    q_jid_r;
  logic [ST_W-1:0]     q_st_r;

  logic             rd_en;
  logic             mem_we;
  logic             hit;
  logic             last;
  logic [ST_W-1:0]  want_st;
  logic [JID_W-1:0] mx;
  logic [JID_W:0]   inc;

  assign rd_en   = ((state_r == S_SCAN) || (state_r == S_MAX)) && (idx_r < CNT_END);
  assign last    = rd_vld_r && (rd_idx_r == LAST_IDX);
  assign want_st = (op_r == FN_FIRST_FG) ? ST_FG : ST_STOP;
  assign mx      = (q_v_r && (q_jid_r > max_r)) ? q_jid_r : max_r;

  always_comb begin
    case (op_r)
      FN_ADD:                  hit = !q_v_r;
      FN_DELETE, FN_FIND_PID:  hit = q_v_r && (q_pid_r == pid_r);
      FN_FIND_JID:             hit = q_v_r && (q_jid_r == jid_r);
      FN_FIRST_FG, FN_FIRST_ST: hit = q_v_r && (q_st_r == want_st);
      default:                 hit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    next_jid_nxt = next_jid_r;
    idx_nxt      = idx_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    max_nxt      = max_r;
    op_nxt       = op_r;
    pid_nxt      = pid_r;
    jid_nxt      = jid_r;
    st_nxt       = st_r;
    res_ok_nxt   = res_ok_r;
    res_pid_nxt  = res_pid_r;
    res_jid_nxt  = res_jid_r;
    res_st_nxt   = res_st_r;
    mem_we       = 1'b0;
    inc          = '0;

    if (rd_en) begin
      idx_nxt    = idx_r + 1'b1;
      rd_vld_nxt = 1'b1;
      rd_idx_nxt = idx_r[IDX_W-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_func;
          pid_nxt     = in_pid;
          jid_nxt     = in_job_id;
          st_nxt      = in_run_state;
          idx_nxt     = '0;
          max_nxt     = '0;
          res_ok_nxt  = 1'b0;
          res_pid_nxt = '0;
          res_jid_nxt = '0;
          res_st_nxt  = '0;
          state_nxt   = S_SCAN;
          case (in_func)
            FN_ADD, FN_DELETE, FN_FIND_PID: begin
              if (in_pid == '0) begin
                state_nxt = S_DONE;
              end
            end
            FN_FIND_JID: begin
              if (in_job_id == '0) begin
                state_nxt = S_DONE;
              end
            end
            FN_FIRST_FG, FN_FIRST_ST: begin
            end
            FN_CLEAR: begin
              valid_nxt  = '0;
              res_ok_nxt = 1'b1;
              state_nxt  = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_vld_r && hit) begin
          res_ok_nxt = 1'b1;
          if (op_r == FN_ADD) begin
            mem_we              = 1'b1;
            valid_nxt[rd_idx_r] = 1'b1;
            res_pid_nxt         = pid_r;
            res_jid_nxt         = next_jid_r;
            res_st_nxt          = st_r;
            inc                 = {1'b0, next_jid_r} + 1'b1;
            next_jid_nxt        = (inc > JID_END) ? JID_W'(1) : inc[JID_W-1:0];
            state_nxt           = S_DONE;
          end else begin
            res_pid_nxt = q_pid_r;
            res_jid_nxt = q_jid_r;
            res_st_nxt  = q_st_r;
            if (op_r == FN_DELETE) begin
              valid_nxt[rd_idx_r] = 1'b0;
              idx_nxt             = '0;
              rd_vld_nxt          = 1'b0;
              max_nxt             = '0;
              state_nxt           = S_MAX;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end else if (last) begin
          state_nxt = S_DONE;
        end
      end
      S_MAX: begin
        if (rd_vld_r) begin
          max_nxt = mx;
        end
        if (last) begin
          inc          = {1'b0, mx} + 1'b1;
          next_jid_nxt = (inc > JID_END) ? JID_W'(1) : inc[JID_W-1:0];
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      next_jid_r <= JID_W'(1);
      rd_vld_r   <= 1'b0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      valid_r    <= valid_nxt;
      next_jid_r <= next_jid_nxt;
      rd_vld_r   <= rd_vld_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    max_r     <= max_nxt;
    op_r      <= op_nxt;
    pid_r     <= pid_nxt;
    jid_r     <= jid_nxt;
    st_r      <= st_nxt;
    res_ok_r  <= res_ok_nxt;
    res_pid_r <= res_pid_nxt;
    res_jid_r <= res_jid_nxt;
    res_st_r  <= res_st_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_pid[rd_idx_r] <= pid_r;
      mem_jid[rd_idx_r] <= next_jid_r;
      mem_st[rd_idx_r]  <= st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_v_r   <= valid_r[idx_r[IDX_W-1:0]];
      q_pid_r <= mem_pid[idx_r[IDX_W-1:0]];
      q_jid_r <= mem_jid[idx_r[IDX_W-1:0]];
      q_st_r  <= mem_st[idx_r[IDX_W-1:0]];
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_DONE);
  assign out_ok           = res_ok_r;
  assign out_found_pid    = res_pid_r;
  assign out_found_job_id = res_jid_r;
  assign out_found_state  = res_st_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result word waits");

  a_next_jid_range: assert property (@(posedge clk) disable iff (!rst_n)
    (next_jid_r != '0) && ({1'b0, next_jid_r} <= JID_END))
    else $error("next job id out of range");

  a_ready_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !in_stall && !out_valid)
    else $error("sequencer not idle after result word taken");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |->
      (out_found_pid == '0) && (out_found_job_id == '0) && (out_found_state == '0))
    else $error("failed result carries entry fields");

endmodule

FILE: tb/job_table_engine_tb.sv
// Self-checking testbench for job_table_engine: a table of directed operations, then
// randomized add/delete/find/clear traffic under varying idle and stall patterns.
// Depends on jte_pkg and the job_table_engine RTL.
`timescale 1ns / 1ps

module job_table_engine_tb;
  import jte_pkg::*;

  localparam int NE = NUM_ENTRIES_DEF;
  localparam int PW = PID_BITS_DEF;
  localparam int JW = $clog2(NE + 1);
  localparam logic [PW-1:0] PID_MAX = '1;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam logic [ST_W-1:0] ST_NONE = 2'd0;
  localparam logic [ST_W-1:0] ST_BG = 2'd2;
  localparam int DIR_ROWS = 24;
  localparam int RAND_PER_PHASE = 460;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 2 * NE + 8;
  localparam int MAX_CYCLES = 600000;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PW-1:0] pid;
    logic [JW-1:0] jid;
    logic [ST_W-1:0] st;
  } job_op_t;

  typedef struct packed {
    logic ok;
    logic [PW-1:0] pid;
    logic [JW-1:0] jid;
    logic [ST_W-1:0] st;
  } job_answer_t;

  typedef struct packed {
    job_op_t op;
    logic known;
    job_answer_t answer;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FUNC_W-1:0] in_func = '0;
  logic [PW-1:0] in_pid = '0;
  logic [JW-1:0] in_job_id = '0;
  logic [ST_W-1:0] in_run_state = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_ok;
  logic [PW-1:0] out_found_pid;
  logic [JW-1:0] out_found_job_id;
  logic [ST_W-1:0] out_found_state;

  logic [PW-1:0] tbl_pid [NE];
  logic [JW-1:0] tbl_jid [NE];
  logic [ST_W-1:0] tbl_st [NE];
  logic [JW-1:0] next_jid;

  job_answer_t pending_answers [$];
  job_answer_t got_answer;
  op_row_t dir_rows [DIR_ROWS];
  int errors = 0;
  int cycles = 0;
  int snd_idle = 0;
  int rcv_stall = 0;
  int hold_cnt = 0;

  job_table_engine u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_pid(in_pid),
    .in_job_id(in_job_id),
    .in_run_state(in_run_state),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_ok(out_ok),
    .out_found_pid(out_found_pid),
    .out_found_job_id(out_found_job_id),
    .out_found_state(out_found_state)
  );

  always #6 clk = ~clk;

  function automatic job_answer_t slot_answer(int s);
    job_answer_t r;
    r.ok = 1'b1;
    r.pid = tbl_pid[s];
    r.jid = tbl_jid[s];
    r.st = tbl_st[s];
    return r;
  endfunction

  function automatic int slot_of_pid(logic [PW-1:0] p);
    int s;
    s = -1;
    if (p != '0) begin
      for (int i = 0; i < NE; i++) begin
        if (s < 0 && tbl_pid[i] == p) s = i;
      end
    end
    return s;
  endfunction

  function automatic job_answer_t run_job_op(job_op_t w);
    job_answer_t r;
    int s;
    int mx;
    logic [ST_W-1:0] want;
    r = '0;
    s = -1;
    case (w.func)
      FN_ADD: begin
        if (w.pid != '0) begin
          for (int i = 0; i < NE; i++) begin
            if (s < 0 && tbl_pid[i] == '0) s = i;
          end
        end
        if (s >= 0) begin
          tbl_pid[s] = w.pid;
          tbl_st[s] = w.st;
          tbl_jid[s] = next_jid;
          next_jid = (next_jid >= JW'(NE)) ? JW'(1) : next_jid + JW'(1);
          r = slot_answer(s);
        end
      end
      FN_DELETE: begin
        s = slot_of_pid(w.pid);
        if (s >= 0) begin
          r = slot_answer(s);
          tbl_pid[s] = '0;
          tbl_jid[s] = '0;
          tbl_st[s] = '0;
          mx = 0;
          for (int i = 0; i < NE; i++) begin
            if (int'(tbl_jid[i]) > mx) mx = int'(tbl_jid[i]);
          end
          mx = mx + 1;
          if (mx > NE) mx = 1;
          next_jid = JW'(mx);
        end
      end
      FN_FIND_PID: begin
        s = slot_of_pid(w.pid);
        if (s >= 0) r = slot_answer(s);
      end
      FN_FIND_JID: begin
        if (w.jid != '0) begin
          for (int i = 0; i < NE; i++) begin
            if (s < 0 && tbl_jid[i] == w.jid) s = i;
          end
        end
        if (s >= 0) r = slot_answer(s);
      end
      FN_FIRST_FG, FN_FIRST_ST: begin
        want = (w.func == FN_FIRST_FG) ? ST_FG : ST_STOP;
        for (int i = 0; i < NE; i++) begin
          if (s < 0 && tbl_st[i] == want) s = i;
        end
        if (s >= 0) r = slot_answer(s);
      end
      FN_CLEAR: begin
        for (int i = 0; i < NE; i++) begin
          tbl_pid[i] = '0;
          tbl_jid[i] = '0;
          tbl_st[i] = '0;
        end
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Fill mode favors adds so the table runs full and job ids wrap.
  function automatic job_op_t pick_job_op(bit fill);
    job_op_t w;
    int live [$];
    int r;
    int cuts [7];
    logic [FUNC_W-1:0] ops [7];
    ops = '{FN_ADD, FN_DELETE, FN_FIND_PID, FN_FIND_JID, FN_FIRST_FG, FN_FIRST_ST, FN_CLEAR};
    if (fill) cuts = '{62, 76, 83, 88, 92, 96, 98};
    else cuts = '{28, 48, 64, 76, 84, 92, 97};
    for (int i = 0; i < NE; i++) begin
      if (tbl_pid[i] != '0) live.push_back(i);
    end
    w.func = FN_UNUSED;
    w.pid = PW'($urandom);
    w.jid = JW'($urandom);
    w.st = ST_W'($urandom);
    r = $urandom_range(99);
    for (int k = 6; k >= 0; k--) begin
      if (r < cuts[k]) w.func = ops[k];
    end
    r = $urandom_range(99);
    if (r < 8) w.pid = '0;
    else if (r < 20) w.pid = PW'($urandom);
    else if (w.func != FN_ADD && live.size() > 0 && r < 80)
      w.pid = tbl_pid[live[$urandom_range(live.size() - 1)]];
    else w.pid = PW'($urandom_range(40, 1));
    r = $urandom_range(99);
    if (r < 15) w.jid = JW'($urandom);
    else if (live.size() > 0 && r < 80) w.jid = tbl_jid[live[$urandom_range(live.size() - 1)]];
    else w.jid = JW'($urandom_range(NE, 1));
    return w;
  endfunction

  function automatic op_row_t op_row(logic [FUNC_W-1:0] f, logic [PW-1:0] p,
                                     logic [JW-1:0] j, logic [ST_W-1:0] s);
    op_row_t r;
    r = '0;
    r.op.func = f;
    r.op.pid = p;
    r.op.jid = j;
    r.op.st = s;
    return r;
  endfunction

  function automatic op_row_t op_row_known(logic [FUNC_W-1:0] f, logic [PW-1:0] p,
                                           logic [JW-1:0] j, logic [ST_W-1:0] s,
                                           logic ok, logic [PW-1:0] fp,
                                           logic [JW-1:0] fj, logic [ST_W-1:0] fs);
    op_row_t r;
    r = op_row(f, p, j, s);
    r.known = 1'b1;
    r.answer.ok = ok;
    r.answer.pid = fp;
    r.answer.jid = fj;
    r.answer.st = fs;
    return r;
  endfunction

  task automatic send_word(job_op_t w, logic known, job_answer_t answer);
    job_answer_t pred;
    while ($urandom_range(99) < snd_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_func <= w.func;
    in_pid <= w.pid;
    in_job_id <= w.jid;
    in_run_state <= w.st;
    do @(posedge clk); while (in_stall);
    pred = run_job_op(w);
    pending_answers.push_back(known ? answer : pred);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt = hold_cnt - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
      end else begin
        got_answer = pending_answers.pop_front();
        check_field("ok", 32'(got_answer.ok), 32'(out_ok));
        check_field("found_pid", 32'(got_answer.pid), 32'(out_found_pid));
        check_field("found_job_id", 32'(got_answer.jid), 32'(out_found_job_id));
        check_field("found_state", 32'(got_answer.st), 32'(out_found_state));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int snd_pct [4];
    int rcv_pct [4];
    snd_pct = '{0, 57, 0, 37};
    rcv_pct = '{0, 0, 57, 37};
    for (int i = 0; i < NE; i++) begin
      tbl_pid[i] = '0;
      tbl_jid[i] = '0;
      tbl_st[i] = '0;
    end
    next_jid = JW'(1);

    dir_rows[0] = op_row_known(FN_FIRST_FG, 0, 0, 0, 0, 0, 0, ST_NONE);
    dir_rows[1] = op_row_known(FN_FIND_PID, PID_MAX, 0, 0, 0, 0, 0, ST_NONE);
    dir_rows[2] = op_row_known(FN_ADD, 0, 0, ST_FG, 0, 0, 0, ST_NONE);
    dir_rows[3] = op_row_known(FN_ADD, PID_MAX, 31, ST_FG, 1, PID_MAX, 1, ST_FG);
    dir_rows[4] = op_row_known(FN_ADD, 1, 0, ST_STOP, 1, 1, 2, ST_STOP);
    dir_rows[5] = op_row_known(FN_ADD, 5, 0, ST_NONE, 1, 5, 3, ST_NONE);
    dir_rows[6] = op_row_known(FN_ADD, 1, 0, ST_BG, 1, 1, 4, ST_BG);
    dir_rows[7] = op_row_known(FN_FIND_PID, 1, 0, 0, 1, 1, 2, ST_STOP);
    dir_rows[8] = op_row_known(FN_FIND_PID, 0, 2, 0, 0, 0, 0, ST_NONE);
    dir_rows[9] = op_row_known(FN_FIND_JID, 1, 0, 0, 0, 0, 0, ST_NONE);
    dir_rows[10] = op_row_known(FN_FIND_JID, 0, 31, 0, 0, 0, 0, ST_NONE);
    dir_rows[11] = op_row(FN_FIND_JID, 0, 3, 0);
    dir_rows[12] = op_row(FN_FIRST_FG, 0, 0, 0);
    dir_rows[13] = op_row(FN_FIRST_ST, 0, 0, 0);
    dir_rows[14] = op_row(FN_DELETE, 1, 0, 0);
    dir_rows[15] = op_row_known(FN_DELETE, 0, 0, 0, 0, 0, 0, ST_NONE);
    dir_rows[16] = op_row(FN_DELETE, 77, 0, 0);
    dir_rows[17] = op_row(FN_FIND_PID, 1, 0, 0);
    dir_rows[18] = op_row(FN_ADD, 9, 0, ST_BG);
    dir_rows[19] = op_row_known(FN_UNUSED, PID_MAX, 31, ST_STOP, 0, 0, 0, ST_NONE);
    dir_rows[20] = op_row_known(FN_CLEAR, PID_MAX, 31, ST_STOP, 1, 0, 0, ST_NONE);
    dir_rows[21] = op_row(FN_FIRST_ST, 0, 0, 0);
    dir_rows[22] = op_row(FN_ADD, 2, 0, ST_STOP);
    dir_rows[23] = op_row(FN_FIND_JID, 0, JW'(NE), 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) send_word(dir_rows[k].op, dir_rows[k].known, dir_rows[k].answer);

    for (int p = 0; p < 4; p++) begin
      if (p == 2) hold_cnt = HOLD_CYCLES;
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        snd_idle = (k % 100 < 15) ? 0 : snd_pct[p];
        rcv_stall = (k % 100 < 15) ? 0 : rcv_pct[p];
        send_word(pick_job_op((k / 40) % 2 == 0), 1'b0, '0);
      end
      // hold input until every answer is back
      @(negedge clk);
      in_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/jte_pkg.sv
rtl/core/job_table_engine.sv
tb/job_table_engine_tb.sv
